// ----- rtl/sha1sh_pkg.sv -----
// Shared types, constants and round helpers for the SHA-1 stream hasher.
package sha1sh_pkg;

	localparam int QueueDepth = 4;
	localparam int QueuePtrW  = $clog2(QueueDepth);

	// One message item as it travels from the front end to the hashing core.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last;
	} item_t;

	typedef logic [31:0] word_t;

	localparam word_t InitChain [5] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};

	localparam word_t RoundConst [4] = '{
		32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
	};

	localparam logic [7:0] PadByte    = 8'h80;
	localparam logic [6:0] RoundsLast = 7'd80;
	localparam logic [5:0] LenFill    = 6'd56;

	// Phase index of a round: 0..19, 20..39, 40..59, 60..79.
	function automatic logic [1:0] round_phase(input logic [6:0] rnd);
		logic [1:0] ph;
		if (rnd < 7'd20) begin
			ph = 2'd0;
		end else if (rnd < 7'd40) begin
			ph = 2'd1;
		end else if (rnd < 7'd60) begin
			ph = 2'd2;
		end else begin
			ph = 2'd3;
		end
		return ph;
	endfunction

	function automatic word_t round_f(input logic [1:0] ph, input word_t b, input word_t c,
			input word_t d);
		word_t f;
		case (ph)
			2'd0: f = (b & c) | (~b & d);
			2'd2: f = (b & c) | (b & d) | (c & d);
			default: f = b ^ c ^ d;
		endcase
		return f;
	endfunction

endpackage

// ----- rtl/sha1sh_front.sv -----
// Input stage: registers stream items and drops those that carry no work.
module sha1sh_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [7:0] data_byte
	input  logic                 s_tuser,   // [0] has_byte
	input  logic                 s_tlast,
	output logic                 push,
	output sha1sh_pkg::item_t    push_item,
	input  logic                 queue_full
);
	import sha1sh_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	logic  useful;
	logic  drain;

	// An item with neither a byte nor an end mark changes nothing.
	assign useful    = item_s1.has_byte | item_s1.last;
	assign drain     = valid_s1 & (~useful | ~queue_full);
	assign push      = valid_s1 & useful & ~queue_full;
	assign push_item = item_s1;
	assign s_tready  = ~valid_s1 | drain;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.data_byte <= s_tdata;
			item_s1.has_byte  <= s_tuser;
			item_s1.last      <= s_tlast;
		end
	end

endmodule

// ----- rtl/sha1sh_queue.sv -----
// Short item queue between the front end and the hashing core.
module sha1sh_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sha1sh_pkg::item_t push_item,
	output logic              full,
	input  logic              pop,
	output sha1sh_pkg::item_t pop_item,
	output logic              empty
);
	import sha1sh_pkg::*;

	item_t                mem_q [QueueDepth];
	logic [QueuePtrW-1:0] wr_ptr_q;
	logic [QueuePtrW-1:0] rd_ptr_q;
	logic [QueuePtrW:0]   count_q;

	assign full     = (count_q == (QueuePtrW+1)'(QueueDepth));
	assign empty    = (count_q == '0);
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ----- rtl/sha1sh_core.sv -----
// Hashing core: block assembly, padding, 80-round compression and digest output.
module sha1sh_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	input  sha1sh_pkg::item_t pop_item,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [31:0]       m_tdata,   // [31:0] digest_word
	output logic [2:0]        m_tuser,   // [2:0] word_index
	output logic              m_tlast
);
	import sha1sh_pkg::*;

	localparam logic [2:0] StLoad = 3'd0;
	localparam logic [2:0] StPad  = 3'd1;
	localparam logic [2:0] StLen  = 3'd2;
	localparam logic [2:0] StRun  = 3'd3;
	localparam logic [2:0] StOut  = 3'd4;

	logic [2:0]  state_q;
	word_t       sched_q [16];
	logic [23:0] acc_q;
	logic [5:0]  fill_q;
	logic [60:0] count_q;
	word_t       chain_q [5];
	word_t       a_q, b_q, c_q, d_q, e_q;
	logic [6:0]  rnd_q;
	logic        fin_q;
	logic        pad80_q;
	logic        final_q;
	logic [2:0]  idx_q;
	logic        out_valid_q;
	word_t       out_word_q;
	logic [2:0]  out_idx_q;

	logic        put_en;
	logic [7:0]  put_byte;
	logic [5:0]  fill_put;
	logic        word_done;
	logic        len_en;
	word_t       len_word;
	logic        shift_en;
	word_t       shift_in;
	logic        round_en;
	word_t       new_w;
	word_t       mix;
	logic [1:0]  phase;
	word_t       t_val;
	logic        emit;

	assign pop      = (state_q == StLoad) & ~empty;
	assign put_en   = (pop & pop_item.has_byte) | (state_q == StPad);
	assign put_byte = (state_q == StPad) ? (pad80_q ? PadByte : 8'h00) : pop_item.data_byte;
	assign fill_put = fill_q + 6'd1;
	assign word_done = put_en & (fill_q[1:0] == 2'd3);

	// The length words land in slots 14 and 15; the fill position tells which.
	assign len_en   = (state_q == StLen);
	assign len_word = fill_q[2] ? {count_q[28:0], 3'b000} : count_q[60:29];

	assign round_en = (state_q == StRun) & (rnd_q != RoundsLast);
	assign mix      = sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0];
	assign new_w    = {mix[30:0], mix[31]};
	assign phase    = round_phase(rnd_q);
	assign t_val    = {a_q[26:0], a_q[31:27]} + round_f(phase, b_q, c_q, d_q) + e_q +
		sched_q[0] + RoundConst[phase];

	assign shift_en = word_done | len_en | round_en;
	always_comb begin
		if (round_en) begin
			shift_in = new_w;
		end else if (len_en) begin
			shift_in = len_word;
		end else begin
			shift_in = {acc_q, put_byte};
		end
	end

	assign emit = (state_q == StOut) & (~out_valid_q | m_tready);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_word_q;
	assign m_tuser  = out_idx_q;
	assign m_tlast  = (out_idx_q == 3'd4);

	// The schedule window doubles as the block buffer: words enter at the top
	// while loading, and during the rounds the head is always the current word.
	always_ff @(posedge clk) begin
		if (shift_en) begin
			for (int i = 0; i < 15; i++) begin
				sched_q[i] <= sched_q[i+1];
			end
			sched_q[15] <= shift_in;
		end
		if (put_en) begin
			acc_q <= {acc_q[15:0], put_byte};
		end
		if (round_en) begin
			e_q <= d_q;
			d_q <= c_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			b_q <= a_q;
			a_q <= t_val;
		end else if (state_q != StRun) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end
		if (emit) begin
			out_word_q <= chain_q[idx_q];
			out_idx_q  <= idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= StLoad;
			fill_q      <= '0;
			count_q     <= '0;
			rnd_q       <= '0;
			fin_q       <= 1'b0;
			pad80_q     <= 1'b0;
			final_q     <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 5; i++) begin
				chain_q[i] <= InitChain[i];
			end
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				StLoad: begin
					if (pop) begin
						if (pop_item.has_byte) begin
							fill_q <= fill_put;
							if (count_q != '1) begin
								count_q <= count_q + 61'd1;
							end
						end
						if (pop_item.last) begin
							fin_q   <= 1'b1;
							pad80_q <= 1'b1;
						end
						if (pop_item.has_byte && fill_put == 6'd0) begin
							state_q <= StRun;
						end else if (pop_item.last) begin
							state_q <= StPad;
						end
					end
				end
				StPad: begin
					pad80_q <= 1'b0;
					fill_q  <= fill_put;
					if (fill_put == 6'd0) begin
						state_q <= StRun;
					end else if (fill_put == LenFill) begin
						state_q <= StLen;
					end
				end
				StLen: begin
					fill_q <= fill_q + 6'd4;
					if (fill_q[2]) begin
						final_q <= 1'b1;
						state_q <= StRun;
					end
				end
				StRun: begin
					if (rnd_q == RoundsLast) begin
						rnd_q      <= '0;
						chain_q[0] <= chain_q[0] + a_q;
						chain_q[1] <= chain_q[1] + b_q;
						chain_q[2] <= chain_q[2] + c_q;
						chain_q[3] <= chain_q[3] + d_q;
						chain_q[4] <= chain_q[4] + e_q;
						if (final_q) begin
							state_q <= StOut;
						end else if (fin_q) begin
							state_q <= StPad;
						end else begin
							state_q <= StLoad;
						end
					end else begin
						rnd_q <= rnd_q + 7'd1;
					end
				end
				StOut: begin
					if (emit) begin
						if (idx_q == 3'd4) begin
							idx_q   <= '0;
							fill_q  <= '0;
							count_q <= '0;
							fin_q   <= 1'b0;
							pad80_q <= 1'b0;
							final_q <= 1'b0;
							state_q <= StLoad;
							for (int i = 0; i < 5; i++) begin
								chain_q[i] <= InitChain[i];
							end
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= StLoad;
				end
			endcase
		end
	end

endmodule

// ----- rtl/sha1_stream_hasher_unit.sv -----
// Byte stream SHA-1 hasher: after the last item the core pads the message, appends the
// bit length and runs one or two compressions before word 0 leaves.
// Throughput: one byte per cycle in the core while the queue holds items; while a 64-byte
// block is compressed, a four-entry queue lets the input keep taking items until full.
// Digest words leave through an output register, one per cycle while accepted.
// Asynchronous reset loads the initial chaining value and empties the queue.
module sha1_stream_hasher_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] has_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] digest_word
	output logic [2:0]  m_tuser,   // [2:0] word_index
	output logic        m_tlast
);
	import sha1sh_pkg::*;

	logic  push;
	item_t push_item;
	logic  queue_full;
	logic  pop;
	item_t pop_item;
	logic  queue_empty;

	sha1sh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.push       (push),
		.push_item  (push_item),
		.queue_full (queue_full)
	);

	sha1sh_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (queue_empty)
	);

	sha1sh_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (queue_empty),
		.pop_item (pop_item),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
